/* hdl/hspc_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and the cordic angle table for the hsi shadow classifier
// no dependencies

package hspc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int DIV_BITS     = 13;
    // input stage + cordic steps + hue/saturation finish
    localparam int PIPE_DEPTH   = CORDIC_STEPS + 2;

    localparam int CW = 26;   // cordic x, y, z width (signed)
    localparam int RW = 24;   // divider remainder width

    localparam logic [12:0] SQRT3_Q12  = 13'd7094;
    localparam logic [14:0] HUE_FULL   = 15'd23040;   // 360 degrees in q9.6
    localparam logic [12:0] SAT_ONE    = 13'd4096;
    localparam logic signed [CW-1:0] Z_QUARTER = 26'sd5898240;   // 90 * 65536
    localparam logic signed [CW-1:0] Z_HALF    = 26'sd11796480;  // 180 * 65536

    localparam int REG_RATIO_LOW  = 0;
    localparam int REG_RATIO_HIGH = 1;
    localparam int REG_HUE_LIMIT  = 2;
    localparam int REG_SAT_LIMIT  = 3;

    typedef logic signed [CW-1:0] cw_t;

    // atan(2^-i) in degrees * 65536
    function automatic cw_t atan_q16(input int i);
        cw_t a;
        case (i)
            0:  a = 26'sd2949120;
            1:  a = 26'sd1740967;
            2:  a = 26'sd919879;
            3:  a = 26'sd466945;
            4:  a = 26'sd234379;
            5:  a = 26'sd117304;
            6:  a = 26'sd58666;
            7:  a = 26'sd29335;
            8:  a = 26'sd14668;
            9:  a = 26'sd7334;
            10: a = 26'sd3667;
            11: a = 26'sd1833;
            12: a = 26'sd917;
            13: a = 26'sd458;
            14: a = 26'sd229;
            15: a = 26'sd115;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/hsi_shadow_pixel_classifier_core.sv */
`timescale 1ns / 1ps
// top level of the hsi shadow pixel classifier
// depends on hspc_pkg and hspc_hsi_pipe
//
// usage:
//   s_ channel carries one request per pixel: the current rgb pixel and the
//   background rgb pixel at the same place. m_ channel returns one result per
//   request, bit 0 of m_tdata set when the pixel is shadow.
//   cfg_ port writes the thresholds (ratio low/high, hue limit, saturation
//   limit); write only while no request is in flight.
// throughput: one pixel per clock, back to back while the output is not stalled, set by
//   the fully pipelined cordic and divider (one step per register stage)
// path from accept to m_tvalid: input stage, 16 cordic stages
//   (the 13 divider steps run beside them), hue/saturation finish, compare
// reset: aresetn low clears all valid bits and loads the default thresholds
// stall: when m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated

module hsi_shadow_pixel_classifier_core
    import hspc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cur_red, cur_green, cur_blue, bg_red, bg_green, bg_blue
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // is_shadow, zero fill
    output logic [7:0]  m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // threshold registers
    logic [15:0] ratio_low_reg;
    logic [15:0] ratio_high_reg;
    logic [14:0] hue_limit_reg;
    logic [12:0] sat_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_low_reg  <= 16'd2048;
            ratio_high_reg <= 16'd4096;
            hue_limit_reg  <= 15'd640;
            sat_limit_reg  <= 13'd410;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                2'(REG_RATIO_LOW):  ratio_low_reg  <= cfg_data;
                2'(REG_RATIO_HIGH): ratio_high_reg <= cfg_data;
                2'(REG_HUE_LIMIT):  hue_limit_reg  <= cfg_data[14:0];
                2'(REG_SAT_LIMIT):  sat_limit_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // one global advance: everything moves unless a result is stuck at the output
    logic m_tvalid_reg;
    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // valid bits travel beside the data stages
    logic [PIPE_DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // hue, saturation and intensity of both pixels
    logic [14:0] cur_hue;
    logic [14:0] bg_hue;
    logic [12:0] cur_sat;
    logic [12:0] bg_sat;
    logic [9:0]  cur_sum;
    logic [9:0]  bg_sum;

    hspc_hsi_pipe u_cur (
        .aclk  (aclk),
        .en    (en),
        .red   (s_tdata[7:0]),
        .green (s_tdata[15:8]),
        .blue  (s_tdata[23:16]),
        .hue   (cur_hue),
        .sat   (cur_sat),
        .sum   (cur_sum)
    );

    hspc_hsi_pipe u_bg (
        .aclk  (aclk),
        .en    (en),
        .red   (s_tdata[31:24]),
        .green (s_tdata[39:32]),
        .blue  (s_tdata[47:40]),
        .hue   (bg_hue),
        .sat   (bg_sat),
        .sum   (bg_sum)
    );

    // final tests: intensity ratio by cross multiply, hue and saturation gaps
    logic [25:0] lhs;
    logic [25:0] lo_prod;
    logic [25:0] hi_prod;
    logic [14:0] dh;
    logic [12:0] ds;
    logic        shadow_next;

    always_comb begin
        lhs     = {4'b0, cur_sum, 12'b0};
        lo_prod = 26'(ratio_low_reg) * 26'(bg_sum);
        hi_prod = 26'(ratio_high_reg) * 26'(bg_sum);
        dh      = (cur_hue >= bg_hue) ? (cur_hue - bg_hue) : (bg_hue - cur_hue);
        ds      = (cur_sat >= bg_sat) ? (cur_sat - bg_sat) : (bg_sat - cur_sat);
        // a zero sum in either pixel never counts as shadow
        shadow_next = (cur_sum != '0) && (bg_sum != '0) &&
                      (lhs >= lo_prod) && (lhs <= hi_prod) &&
                      (dh <= hue_limit_reg) && (ds <= sat_limit_reg);
    end

    logic shadow_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            shadow_reg <= shadow_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, shadow_reg};

endmodule

/* hdl/hspc_hsi_pipe.sv */
`timescale 1ns / 1ps
// pipelined hue (cordic) and saturation (restoring divider) of one rgb pixel
// depends on hspc_pkg

module hspc_hsi_pipe
    import hspc_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic [14:0] hue,
    output logic [12:0] sat,
    output logic [9:0]  sum
);

    // input stage logic
    logic [9:0]              sum_in;
    logic [7:0]              min_rg;
    logic [7:0]              min_in;
    logic signed [10:0]      xd;
    logic [7:0]              gb_abs;
    cw_t                     x_in;
    cw_t                     y_in;
    cw_t                     x0;
    cw_t                     y0;
    cw_t                     z0;
    logic [RW-1:0]           rem0;

    always_comb begin
        sum_in = 10'(red) + 10'(green) + 10'(blue);
        min_rg = (red < green) ? red : green;
        min_in = (min_rg < blue) ? min_rg : blue;
        xd     = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
                 - $signed({3'b000, blue});
        gb_abs = (green >= blue) ? (green - blue) : (blue - green);
        x_in   = cw_t'(xd) <<< 12;
        y_in   = $signed({5'b0, 21'(gb_abs) * 21'(SQRT3_Q12)});
        // left half plane: turn by -90 degrees first
        if (x_in < 0) begin
            x0 = y_in;
            y0 = -x_in;
            z0 = Z_QUARTER;
        end else begin
            x0 = x_in;
            y0 = y_in;
            z0 = '0;
        end
        // rounded quotient: (2*3*min*4096 + sum) / (2*sum)
        rem0 = RW'(min_in) * RW'(24576) + RW'(sum_in);
    end

    cw_t            x_reg   [0:CORDIC_STEPS];
    cw_t            y_reg   [0:CORDIC_STEPS];
    cw_t            z_reg   [0:CORDIC_STEPS];
    logic [RW-1:0]  rem_reg [0:CORDIC_STEPS];
    logic [DIV_BITS-1:0] q_reg [0:CORDIC_STEPS];
    logic [10:0]    dv_reg  [0:CORDIC_STEPS];
    logic [9:0]     sum_reg [0:CORDIC_STEPS];
    logic           grey_reg[0:CORDIC_STEPS];
    logic           gge_reg [0:CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            rem_reg[0]  <= rem0;
            q_reg[0]    <= '0;
            dv_reg[0]   <= {sum_in, 1'b0};
            sum_reg[0]  <= sum_in;
            grey_reg[0] <= (red == green) && (green == blue);
            gge_reg[0]  <= (green >= blue);
        end
    end

    genvar s;
    generate
        for (s = 1; s <= CORDIC_STEPS; s++) begin : g_step
            cw_t           x_next;
            cw_t           y_next;
            cw_t           z_next;
            logic [RW-1:0] rem_next;
            logic [DIV_BITS-1:0] q_next;

            always_comb begin
                if (y_reg[s-1] >= 0) begin
                    x_next = x_reg[s-1] + (y_reg[s-1] >>> (s - 1));
                    y_next = y_reg[s-1] - (x_reg[s-1] >>> (s - 1));
                    z_next = z_reg[s-1] + atan_q16(s - 1);
                end else begin
                    x_next = x_reg[s-1] - (y_reg[s-1] >>> (s - 1));
                    y_next = y_reg[s-1] + (x_reg[s-1] >>> (s - 1));
                    z_next = z_reg[s-1] - atan_q16(s - 1);
                end
            end

            if (s <= DIV_BITS) begin : g_div
                logic [RW:0] trial;
                always_comb begin
                    trial = {1'b0, rem_reg[s-1]}
                            - ((RW+1)'(dv_reg[s-1]) << (DIV_BITS - s));
                    if (!trial[RW]) begin
                        rem_next = trial[RW-1:0];
                        q_next   = q_reg[s-1] | (DIV_BITS'(1) << (DIV_BITS - s));
                    end else begin
                        rem_next = rem_reg[s-1];
                        q_next   = q_reg[s-1];
                    end
                end
            end else begin : g_hold
                assign rem_next = rem_reg[s-1];
                assign q_next   = q_reg[s-1];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[s]    <= x_next;
                    y_reg[s]    <= y_next;
                    z_reg[s]    <= z_next;
                    rem_reg[s]  <= rem_next;
                    q_reg[s]    <= q_next;
                    dv_reg[s]   <= dv_reg[s-1];
                    sum_reg[s]  <= sum_reg[s-1];
                    grey_reg[s] <= grey_reg[s-1];
                    gge_reg[s]  <= gge_reg[s-1];
                end
            end
        end
    endgenerate

    // finish: clamp, round to q9.6, fold, saturation
    cw_t         z_last;
    cw_t         z_clamp;
    logic [CW-1:0] z_round;
    logic [14:0] hq;
    logic [14:0] hue_next;
    logic [12:0] sat_next;

    always_comb begin
        z_last = z_reg[CORDIC_STEPS];
        if (z_last < 0) begin
            z_clamp = '0;
        end else if (z_last > Z_HALF) begin
            z_clamp = Z_HALF;
        end else begin
            z_clamp = z_last;
        end
        z_round = $unsigned(z_clamp) + CW'(512);
        hq      = z_round[24:10];
        if (grey_reg[CORDIC_STEPS]) begin
            hue_next = '0;
        end else if (gge_reg[CORDIC_STEPS]) begin
            hue_next = hq;
        end else begin
            hue_next = HUE_FULL - hq;
        end
        sat_next = SAT_ONE - q_reg[CORDIC_STEPS];
    end

    logic [14:0] hue_reg;
    logic [12:0] sat_reg;
    logic [9:0]  sum_out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg     <= hue_next;
            sat_reg     <= sat_next;
            sum_out_reg <= sum_reg[CORDIC_STEPS];
        end
    end

    assign hue = hue_reg;
    assign sat = sat_reg;
    assign sum = sum_out_reg;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// self-checking bench for hsi_shadow_pixel_classifier_core: pixel pairs in, shadow flags out
// depends on hspc_pkg and the core rtl; flags are predicted with a local fixed-point hsi model

module tb
    import hspc_pkg::*;
();

    localparam int    LATENCY   = 19;
    localparam int    N_RANDOM  = 1030;
    localparam longint CYC_LIMIT = 400000;

    // table of atan(2^-i) in degrees * 65536
    localparam longint ATAN_TAB [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [7:0] bg_blue;
        logic [7:0] bg_green;
        logic [7:0] bg_red;
        logic [7:0] cur_blue;
        logic [7:0] cur_green;
        logic [7:0] cur_red;
    } pixel_pair_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // local copy of the thresholds
    logic [15:0] thr_ratio_low, thr_ratio_high;
    logic [14:0] thr_hue_limit;
    logic [12:0] thr_sat_limit;

    bit     expected_flags [$];
    int     mismatches = 0;
    int     flags_checked = 0;
    int     shadow_seen = 0;
    longint cycle_count = 0;
    // receiver and sender behavior
    bit     rx_no_idle = 1'b0;
    int     rx_hold_cycles = 0;
    bit     tx_no_idle = 1'b0;

    hsi_shadow_pixel_classifier_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // floor shift for signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // hue in degrees q9.6 via cordic vectoring
    function automatic longint hue_deg_q6(longint r, longint g, longint b);
        longint x, y, z, t, dx, dy, hq;
        if (r == g && g == b) return 0;
        x = (2 * r - g - b) * 4096;
        y = ((g >= b) ? g - b : b - g) * 7094;
        z = 0;
        // rotate into the right half plane first
        if (x < 0) begin
            t = x; x = y; y = -t; z = 90 * 65536;
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 180 * 65536) z = 180 * 65536;
        hq = (z + 512) >>> 10;
        return (g >= b) ? hq : 23040 - hq;
    endfunction

    function automatic longint sat_q12(longint r, longint g, longint b, longint sum);
        longint m, num;
        m = (r < g) ? r : g;
        m = (m < b) ? m : b;
        num = 3 * m * 4096;
        return 4096 - (2 * num + sum) / (2 * sum);
    endfunction

    function automatic bit classify_shadow(pixel_pair_t p);
        longint sc, sb, lhs, dh, ds, hc, hb, tc, tb;
        sc = p.cur_red + p.cur_green + p.cur_blue;
        sb = p.bg_red + p.bg_green + p.bg_blue;
        // any black pixel can never be shadow
        if (sc == 0 || sb == 0) return 1'b0;
        lhs = sc * 4096;
        hc = hue_deg_q6(p.cur_red, p.cur_green, p.cur_blue);
        hb = hue_deg_q6(p.bg_red, p.bg_green, p.bg_blue);
        tc = sat_q12(p.cur_red, p.cur_green, p.cur_blue, sc);
        tb = sat_q12(p.bg_red, p.bg_green, p.bg_blue, sb);
        dh = (hc >= hb) ? hc - hb : hb - hc;
        ds = (tc >= tb) ? tc - tb : tb - tc;
        return lhs >= longint'(thr_ratio_low) * sb && lhs <= longint'(thr_ratio_high) * sb
            && dh <= longint'(thr_hue_limit) && ds <= longint'(thr_sat_limit);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // cycle counter and watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("hsi_shadow_pixel_classifier_core verification failed");
            $finish;
        end
    end

    // result checker, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_flags.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                bit exp_flag;
                exp_flag = expected_flags.pop_front();
                if (m_tdata[0] !== exp_flag)
                    report_mismatch($sformatf("is_shadow got %b want %b", m_tdata[0], exp_flag));
                if (m_tdata[7:1] !== 7'd0)
                    report_mismatch($sformatf("fill bits got %h", m_tdata[7:1]));
                flags_checked++;
                if (exp_flag) shadow_seen++;
            end
        end
    end

    // receiver: random idling, or a long hold-off counted here
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            m_tready <= rx_no_idle || ($urandom_range(99) >= 28);
        end
    end

    // random request, all 48 bits
    function automatic pixel_pair_t rand_pair();
        return pixel_pair_t'(48'({$urandom, $urandom}));
    endfunction

    // send one request; the expected flag is computed at acceptance
    // s_tvalid stays high into the next request unless the sender idles
    task automatic send_pixel(pixel_pair_t p);
        if (!tx_no_idle) begin
            while ($urandom_range(99) < 28) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        expected_flags.push_back(classify_shadow(p));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_flags.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_reg(int idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_RATIO_LOW:  thr_ratio_low  = value;
            REG_RATIO_HIGH: thr_ratio_high = value;
            REG_HUE_LIMIT:  thr_hue_limit  = value[14:0];
            REG_SAT_LIMIT:  thr_sat_limit  = value[12:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_thresholds(logic [15:0] lo, logic [15:0] hi, logic [15:0] hl,
                                  logic [15:0] sl);
        wait_drained();
        write_reg(REG_RATIO_LOW, lo);
        write_reg(REG_RATIO_HIGH, hi);
        write_reg(REG_HUE_LIMIT, hl);
        write_reg(REG_SAT_LIMIT, sl);
    endtask

    function automatic pixel_pair_t make_pair(int cr, int cg, int cb, int br, int bg, int bb);
        pixel_pair_t p;
        p.cur_red = 8'(cr); p.cur_green = 8'(cg); p.cur_blue = 8'(cb);
        p.bg_red = 8'(br); p.bg_green = 8'(bg); p.bg_blue = 8'(bb);
        return p;
    endfunction

    // darkened copy of a background pixel, the typical shadow case
    function automatic pixel_pair_t shadow_like();
        pixel_pair_t p;
        int k;
        p = rand_pair();
        k = $urandom_range(30, 100);
        p.cur_red   = 8'((p.bg_red * k) / 100 + $urandom_range(3));
        p.cur_green = 8'((p.bg_green * k) / 100 + $urandom_range(3));
        p.cur_blue  = 8'((p.bg_blue * k) / 100 + $urandom_range(3));
        return p;
    endfunction

    // extremes, grey, black, hue wrap, the reset thresholds
    task automatic test_directed();
        send_pixel(make_pair(0, 0, 0, 0, 0, 0));
        send_pixel(make_pair(0, 0, 0, 100, 50, 20));
        send_pixel(make_pair(100, 50, 20, 0, 0, 0));
        send_pixel(make_pair(255, 255, 255, 255, 255, 255));
        send_pixel(make_pair(128, 128, 128, 255, 255, 255));
        send_pixel(make_pair(60, 60, 60, 120, 120, 120));
        send_pixel(make_pair(255, 0, 0, 255, 0, 0));
        send_pixel(make_pair(0, 255, 0, 0, 255, 0));
        send_pixel(make_pair(0, 0, 255, 0, 0, 255));
        // hue near 0 against hue near 360: not circular
        send_pixel(make_pair(200, 10, 12, 200, 12, 10));
        send_pixel(make_pair(100, 5, 6, 200, 10, 10));
        send_pixel(make_pair(0, 255, 255, 255, 0, 255));
        send_pixel(make_pair(1, 0, 0, 2, 0, 0));
        send_pixel(make_pair(50, 40, 30, 100, 80, 60));
        send_pixel(make_pair(25, 20, 15, 100, 80, 60));
        send_pixel(make_pair(1, 1, 0, 255, 255, 254));
        send_pixel(make_pair(10, 200, 90, 20, 255, 170));
    endtask

    task automatic test_thresholds_extremes();
        set_thresholds(16'h0000, 16'hffff, 16'd23040, 16'd4096);
        repeat (30) send_pixel(rand_pair());
        set_thresholds(16'hffff, 16'h0000, 16'h0000, 16'h0000);
        repeat (20) send_pixel(shadow_like());
        // out-of-range values land as masked
        set_thresholds(16'd4096, 16'd4096, 16'hffff, 16'hffff);
        send_pixel(make_pair(100, 50, 20, 100, 50, 20));
        repeat (20) send_pixel(shadow_like());
    endtask

    task automatic test_random(int n, bit mostly_shadow);
        for (int i = 0; i < n; i++) begin
            if (mostly_shadow && $urandom_range(99) < 70) send_pixel(shadow_like());
            else send_pixel(rand_pair());
        end
    endtask

    // hold the receiver off while the sender keeps going
    task automatic test_backpressure();
        wait_drained();
        tx_no_idle = 1'b1;
        rx_hold_cycles = 200;
        test_random(80, 1'b1);
        tx_no_idle = 1'b0;
    endtask

    initial begin
        thr_ratio_low = 16'd2048; thr_ratio_high = 16'd4096;
        thr_hue_limit = 15'd640;  thr_sat_limit = 13'd410;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_thresholds_extremes();
        set_thresholds(16'd2048, 16'd4096, 16'd640, 16'd410);
        test_random(N_RANDOM / 3, 1'b1);
        test_backpressure();
        set_thresholds(16'd1024, 16'd5000, 16'd1500, 16'd800);
        // no idling on either side for a stretch
        rx_no_idle = 1'b1; tx_no_idle = 1'b1;
        test_random(200, 1'b1);
        rx_no_idle = 1'b0; tx_no_idle = 1'b0;
        set_thresholds(16'd3000, 16'd3900, 16'd300, 16'd200);
        test_random(N_RANDOM / 3, 1'b1);
        wait_drained();
        $display("checked %0d flags (%0d shadow) over several threshold settings,",
                 flags_checked, shadow_seen);
        $display("with random idling, a full-speed stretch and a long output stall");
        if (mismatches == 0 && expected_flags.size() == 0) begin
            $display("hsi_shadow_pixel_classifier_core verification clean");
        end else begin
            $display("hsi_shadow_pixel_classifier_core verification failed");
        end
        $finish;
    end

endmodule
